// File: src/stun_binding_response_parser_unit_assert.svh
// Assertion macros for the STUN binding response parser checker
`ifndef STUN_BINDING_RESPONSE_PARSER_UNIT_ASSERT_SVH
`define STUN_BINDING_RESPONSE_PARSER_UNIT_ASSERT_SVH
// Assert that a condition implies another on the same edge
`define SBRP_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
// Assert that a condition implies another on the next edge
`define SBRP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`endif

// File: src/sbrp_pkg.sv
// Package with codes, types and CRC step for the STUN parser
package sbrp_pkg;
    localparam logic [15:0] ATTR_MAPPED   = 16'h0001;
    localparam logic [15:0] ATTR_MAC      = 16'h0008;
    localparam logic [15:0] ATTR_XOR      = 16'h0020;
    localparam logic [15:0] ATTR_PRIO     = 16'h0024;
    localparam logic [15:0] ATTR_FP       = 16'h8028;
    localparam logic [15:0] PORT_MASK     = 16'h2112;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

    typedef enum logic [1:0] {
        PH_HDR   = 2'd0,
        PH_VAL   = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_LENGTH   = 4'd1,
        ERR_MAC_PLACE = 4'd2,
        ERR_MAC_LEN  = 4'd3,
        ERR_PRIO_LEN = 4'd4,
        ERR_FP_PLACE = 4'd5,
        ERR_FP_LEN   = 4'd6,
        ERR_CRC      = 4'd7,
        ERR_NO_MAC   = 4'd8,
        ERR_NO_ADDR  = 4'd9,
        ERR_TRAILING = 4'd10
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        logic         ok;
        logic [3:0]   error_code;
        logic [1:0]   family;
        logic [15:0]  port;
        logic [63:0]  addr_high;
        logic [63:0]  addr_low;
        logic [31:0]  priority_res;
        logic         mac_seen;
        logic [16:0]  mac_offset;
    } out_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int j = 0; j < 8; j++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction
endpackage

// File: src/sbrp_if.sv
// Valid/ready stream interfaces for the STUN parser
interface sbrp_in_if;
    logic            valid;
    logic            ready;
    sbrp_pkg::in_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sbrp_out_if;
    logic            valid;
    logic            ready;
    sbrp_pkg::out_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/stun_binding_response_parser_unit.sv
// Top level of the STUN binding response parser
// Parses one message byte per clock; an accepted request updates the parse
// registers in the same cycle and the byte marked last loads the verdict into
// the output register, so a request may follow every cycle. The verdict shows
// on the result channel in the cycle after the last byte. Input is stalled while
// a verdict sits unread in the output register and the result side is not
// ready to take it. The running CRC-32 is one byte of eight bit steps a
// cycle. MESSAGE-INTEGRITY is not verified: mac_offset tells an external
// HMAC unit how many leading bytes it covers.
module stun_binding_response_parser_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic require_mac_we,
    input  logic require_mac_wdata,
    sbrp_in_if.sink    in_ch,
    sbrp_out_if.source out_ch
);
    import sbrp_pkg::*;

    logic         require_mac_reg;
    logic [16:0]  byte_count_reg, byte_count_next;
    logic [127:0] header_reg, header_next;
    logic [15:0]  msg_len_reg, msg_len_next;
    phase_t       phase_reg, phase_next;
    logic [15:0]  atype_reg, atype_next;
    logic [15:0]  alen_reg, alen_next;
    logic [15:0]  aoff_reg, aoff_next;
    logic [31:0]  vshift_reg, vshift_next;
    logic [31:0]  crc_reg, crc_next;
    logic [31:0]  crc_snap_reg, crc_snap_next;
    logic [3:0]   ferr_reg, ferr_next;
    logic         mac_found_reg, mac_found_next;
    logic [1:0]   mac_follow_reg, mac_follow_next;
    logic [16:0]  mac_prefix_reg, mac_prefix_next;
    logic [31:0]  prio_reg, prio_next;
    logic [15:0]  port_reg, port_next;
    logic [1:0]   family_reg, family_next;
    logic [127:0] addr_reg, addr_next;
    logic         out_valid_reg;
    out_t         out_reg, out_next;

    logic accept;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [16:0] idx, rel, pos, vidx, endp, kk, hk;
        logic [16:0] cnt_new;
        logic        is_xor;
        logic [4:0]  lim;
        logic [3:0]  err;
        logic [31:0] vs;
        b = in_ch.payload.data_byte;
        idx = byte_count_reg;
        byte_count_next = byte_count_reg; header_next = header_reg;
        msg_len_next = msg_len_reg; phase_next = phase_reg; atype_next = atype_reg;
        alen_next = alen_reg; aoff_next = aoff_reg; vshift_next = vshift_reg;
        crc_next = crc_reg; crc_snap_next = crc_snap_reg; ferr_next = ferr_reg;
        mac_found_next = mac_found_reg; mac_follow_next = mac_follow_reg;
        mac_prefix_next = mac_prefix_reg; prio_next = prio_reg; port_next = port_reg;
        family_next = family_reg; addr_next = addr_reg;
        out_next = out_reg;
        rel = idx - 17'd20;
        pos = rel - {1'b0, aoff_reg};
        vidx = pos - 17'd4;
        endp = {1'b0, aoff_reg} + 17'd4 + {1'b0, alen_reg};
        kk = vidx - 17'd4;
        hk = idx - 17'd4;
        is_xor = (atype_reg == ATTR_XOR);
        lim = (vshift_reg[1:0] == 2'd1) ? 5'd4 : (vshift_reg[1:0] == 2'd2) ? 5'd16 : 5'd0;
        vs = {vshift_reg[23:0], b};
        err = ERR_NONE;
        cnt_new = 17'd0;
        if (accept) begin
            if (idx < 17'd20) begin
                if (idx == 17'd2) msg_len_next[15:8] = b;
                else if (idx == 17'd3) msg_len_next[7:0] = b;
                else if (idx >= 17'd4) header_next[127 - 8*hk[3:0] -: 8] = b;
            end else if (rel < {1'b0, msg_len_reg}) begin
                if (phase_reg == PH_VAL) begin
                    if ((atype_reg == ATTR_MAPPED || is_xor) && alen_reg >= 16'd8) begin
                        if (vidx == 17'd1) begin
                            vshift_next = 32'd0;
                            if (b == 8'd1 && alen_reg == 16'd8) vshift_next = 32'd1;
                            if (b == 8'd2 && alen_reg == 16'd20) vshift_next = 32'd2;
                            if (vshift_next != 32'd0) begin
                                family_next = vshift_next[1:0];
                                addr_next = 128'd0;
                            end
                        end else if (vidx == 17'd2) begin
                            port_next[15:8] = b ^ (is_xor ? PORT_MASK[15:8] : 8'd0);
                        end else if (vidx == 17'd3) begin
                            port_next[7:0] = b ^ (is_xor ? PORT_MASK[7:0] : 8'd0);
                        end else if (vidx >= 17'd4 && kk < {12'd0, lim}) begin
                            addr_next[127 - 8*kk[3:0] -: 8] = addr_reg[127 - 8*kk[3:0] -: 8]
                                | (b ^ (is_xor ? header_reg[127 - 8*kk[3:0] -: 8] : 8'd0));
                        end
                    end else if (atype_reg == ATTR_PRIO || atype_reg == ATTR_FP) begin
                        if (vidx < 17'd4) begin
                            vshift_next = vs;
                            if (vidx == 17'd3) begin
                                if (atype_reg == ATTR_PRIO) prio_next = vs;
                                else if (vs != ~crc_snap_reg && ferr_next == ERR_NONE)
                                    ferr_next = ERR_CRC;
                            end
                        end
                    end
                    if (vidx + 17'd1 == {1'b0, alen_reg}) begin
                        aoff_next = endp[15:0];
                        phase_next = PH_HDR;
                    end
                end else begin
                    if (mac_follow_reg != 2'd0 && pos < 17'd2) begin
                        if (pos == 17'd0) begin
                            if (b != 8'h80) begin
                                if (ferr_next == ERR_NONE) ferr_next = ERR_MAC_PLACE;
                                mac_follow_next = 2'd0;
                            end
                        end else begin
                            if (b != 8'h28) begin
                                if (ferr_next == ERR_NONE) ferr_next = ERR_MAC_PLACE;
                            end else if (mac_follow_reg == 2'd2) begin
                                if (ferr_next == ERR_NONE) ferr_next = ERR_MAC_LEN;
                            end else mac_found_next = 1'b1;
                            mac_follow_next = 2'd0;
                        end
                    end
                    if (phase_reg == PH_HDR) begin
                        if (pos == 17'd0) begin
                            if ({1'b0, msg_len_reg} - rel < 17'd4) phase_next = PH_TRAIL;
                            else begin
                                crc_snap_next = crc_reg;
                                atype_next = {b, 8'd0};
                            end
                        end else if (pos == 17'd1) atype_next[7:0] = b;
                        else if (pos == 17'd2) alen_next = {b, 8'd0};
                        else begin
                            alen_next[7:0] = b;
                            // header complete: classify the attribute
                            endp = {1'b0, aoff_reg} + 17'd4 + {1'b0, alen_reg[15:8], b};
                            vshift_next = 32'd0;
                            if (atype_reg == ATTR_MAC) begin
                                if (endp == {1'b0, msg_len_reg}) begin
                                    if (alen_next != 16'd20) begin
                                        if (ferr_next == ERR_NONE) ferr_next = ERR_MAC_LEN;
                                    end else begin
                                        mac_found_next = 1'b1;
                                        mac_prefix_next = 17'd20 + {1'b0, aoff_reg};
                                    end
                                end else if ({1'b0, endp} + 18'd2 > {2'b0, msg_len_reg}) begin
                                    if (ferr_next == ERR_NONE) ferr_next = ERR_MAC_PLACE;
                                end else begin
                                    mac_follow_next = (alen_next == 16'd20) ? 2'd1 : 2'd2;
                                    mac_prefix_next = 17'd20 + {1'b0, aoff_reg};
                                end
                            end else if (atype_reg == ATTR_PRIO) begin
                                if (alen_next != 16'd4 && ferr_next == ERR_NONE)
                                    ferr_next = ERR_PRIO_LEN;
                            end else if (atype_reg == ATTR_FP) begin
                                if (endp != {1'b0, msg_len_reg}) begin
                                    if (ferr_next == ERR_NONE) ferr_next = ERR_FP_PLACE;
                                end else if (alen_next != 16'd4 && ferr_next == ERR_NONE)
                                    ferr_next = ERR_FP_LEN;
                            end
                            if (alen_next == 16'd0) aoff_next = endp[15:0];
                            else phase_next = PH_VAL;
                        end
                    end
                end
            end
            crc_next = crc_byte(crc_reg, b);
            cnt_new = (idx < COUNT_MAX) ? idx + 17'd1 : idx;
            byte_count_next = cnt_new;

            if (in_ch.payload.last) begin
                if (cnt_new != 17'd20 + {1'b0, msg_len_next}) err = ERR_LENGTH;
                else if (ferr_next != ERR_NONE) err = ferr_next;
                else if (require_mac_reg && !mac_found_next) err = ERR_NO_MAC;
                else if (port_next == 16'd0) err = ERR_NO_ADDR;
                else if (!(phase_next == PH_HDR && aoff_next == msg_len_next))
                    err = ERR_TRAILING;
                out_next = '0;
                out_next.error_code = err;
                if (err == ERR_NONE) begin
                    out_next.ok = 1'b1;
                    out_next.family = family_next;
                    out_next.port = port_next;
                    out_next.addr_high = addr_next[127:64];
                    out_next.addr_low = addr_next[63:0];
                    out_next.priority_res = prio_next;
                    out_next.mac_seen = mac_found_next;
                    out_next.mac_offset = mac_found_next ? mac_prefix_next : 17'd0;
                end
                // drop all packet state for the next message
                byte_count_next = 17'd0; header_next = '0; msg_len_next = '0;
                phase_next = PH_HDR; atype_next = '0; alen_next = '0; aoff_next = '0;
                vshift_next = '0; crc_next = '1; crc_snap_next = '0;
                ferr_next = ERR_NONE; mac_found_next = 1'b0; mac_follow_next = 2'd0;
                mac_prefix_next = '0; prio_next = '0; port_next = '0;
                family_next = '0; addr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            require_mac_reg <= 1'b0;
            byte_count_reg <= '0; header_reg <= '0; msg_len_reg <= '0;
            phase_reg <= PH_HDR; atype_reg <= '0; alen_reg <= '0; aoff_reg <= '0;
            vshift_reg <= '0; crc_reg <= '1; crc_snap_reg <= '0; ferr_reg <= ERR_NONE;
            mac_found_reg <= 1'b0; mac_follow_reg <= 2'd0; mac_prefix_reg <= '0;
            prio_reg <= '0; port_reg <= '0; family_reg <= '0; addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (require_mac_we) require_mac_reg <= require_mac_wdata;
            byte_count_reg <= byte_count_next; header_reg <= header_next;
            msg_len_reg <= msg_len_next; phase_reg <= phase_next;
            atype_reg <= atype_next; alen_reg <= alen_next; aoff_reg <= aoff_next;
            vshift_reg <= vshift_next; crc_reg <= crc_next; crc_snap_reg <= crc_snap_next;
            ferr_reg <= ferr_next; mac_found_reg <= mac_found_next;
            mac_follow_reg <= mac_follow_next; mac_prefix_reg <= mac_prefix_next;
            prio_reg <= prio_next; port_reg <= port_next; family_reg <= family_next;
            addr_reg <= addr_next;
            // hold the verdict until taken; load on the last byte
            if (accept && in_ch.payload.last) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule

// File: src/sbrp_checker.sv
// Port-level checker for the STUN parser and its bind
`include "stun_binding_response_parser_unit_assert.svh"
module sbrp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_last,
    input logic            out_valid,
    input logic            out_ready,
    input sbrp_pkg::out_t  out_payload
);
    import sbrp_pkg::*;
    `SBRP_ASSERT_NEXT(a_last_gives_verdict, clk, rst_n, in_valid && in_ready && in_last, out_valid)
    `SBRP_ASSERT_IMP(a_ok_matches_code, clk, rst_n, out_valid, out_payload.ok == (out_payload.error_code == ERR_NONE))
    `SBRP_ASSERT_IMP(a_fail_clears, clk, rst_n, out_valid && !out_payload.ok, out_payload.port == 16'd0 && out_payload.family == 2'd0)
    `SBRP_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
endmodule

bind stun_binding_response_parser_unit sbrp_checker u_sbrp_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.payload.last),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
